// ===== rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, types and helpers of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uvs_pkg;

   localparam int SEG_W        = 9;
   localparam int MAX_SEG      = 256;
   localparam int FRAC_BITS    = 15;
   localparam int IDX_W        = 17;
   localparam int TEX_W        = 17;
   localparam int POS_W        = 16;
   localparam int DIV_STEPS    = 25;
   localparam int DIV_NUM_W    = 25;
   localparam int CORDIC_STEPS = 20;
   localparam int CORDIC_W     = 32;
   localparam int STEP_IDX_W   = 5;
   // input reg, divider, fold, cordic, rotate, multiply, round
   localparam int LATENCY      = 1 + DIV_STEPS + 1 + CORDIC_STEPS + 3;
   localparam int TEX_DELAY    = LATENCY - DIV_STEPS - 1;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic [SEG_W-1:0] SEG_RESET = 9'd16;

   // register indexes
   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   // arctangent of 2^-i in 2^-32 turn units
   localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
      32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
      32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
      32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304
   };

   typedef struct packed {
      logic [DIV_NUM_W-1:0] num;
      logic [SEG_W-1:0]     rem;
   } div_lane_type;

   typedef struct packed {
      div_lane_type u;
      div_lane_type v;
   } div_pair_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic [1:0]                 quad;
   } cordic_lane_type;

   typedef struct packed {
      cordic_lane_type u;
      cordic_lane_type v;
   } cordic_pair_type;

   typedef struct packed {
      logic [IDX_W-1:0] a0;
      logic [IDX_W-1:0] a1;
      logic [IDX_W-1:0] a2;
      logic [IDX_W-1:0] b0;
      logic [IDX_W-1:0] b1;
      logic [IDX_W-1:0] b2;
      logic             cell_valid;
   } side_type;

   typedef struct packed {
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
   } tex_type;

   // zero acts as one, above the maximum acts as the maximum
   function automatic logic [SEG_W-1:0] seg_count(input logic [SEG_W-1:0] r);
      logic [SEG_W-1:0] c;
      c = r;
      if (r == '0) begin
         c = SEG_W'(1);
      end else if (r > SEG_W'(MAX_SEG)) begin
         c = SEG_W'(MAX_SEG);
      end
      return c;
   endfunction

   // clamp to the signed position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
      logic signed [POS_W-1:0] r;
      r = POS_W'(v);
      if (v > 64'sd32767) begin
         r = 16'sd32767;
      end else if (v < -64'sd32768) begin
         r = -16'sd32768;
      end
      return r;
   endfunction

endpackage

// ===== rtl/uvs_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring division step for the u and v texture lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_div_cell
   import uvs_pkg::*;
(
   input  logic             clock,
   input  logic [SEG_W-1:0] div_u,
   input  logic [SEG_W-1:0] div_v,
   input  div_pair_type     lane_i,
   output div_pair_type     lane_o
);

   div_pair_type lane_ff;
   div_pair_type lane_in;

   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [SEG_W-1:0] d);
      logic [SEG_W:0] t;
      div_lane_type   r;
      t = {l.rem, l.num[DIV_NUM_W-1]};
      if (t >= {1'b0, d}) begin
         r.rem = SEG_W'(t - {1'b0, d});
         r.num = {l.num[DIV_NUM_W-2:0], 1'b1};
      end else begin
         r.rem = t[SEG_W-1:0];
         r.num = {l.num[DIV_NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // shift in one dividend bit, retire one quotient bit
   always_comb begin
      lane_in.u = div_step(lane_i.u, div_u);
      lane_in.v = div_step(lane_i.v, div_v);
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;

endmodule

// ===== rtl/uvs_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// One rotation-mode CORDIC micro-rotation for the theta and phi lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_cordic_cell
   import uvs_pkg::*;
(
   input  logic                  clock,
   input  logic [STEP_IDX_W-1:0] step_idx,
   input  cordic_pair_type       lane_i,
   output cordic_pair_type       lane_o
);

   cordic_pair_type lane_ff;
   cordic_pair_type lane_in;

   function automatic cordic_lane_type rot_step(input cordic_lane_type l,
                                                input logic [STEP_IDX_W-1:0] i);
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      cordic_lane_type            r;
      dx     = l.y >>> i;
      dy     = l.x >>> i;
      r.quad = l.quad;
      if (!l.z[CORDIC_W-1]) begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - ATAN_TURNS[i];
      end else begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + ATAN_TURNS[i];
      end
      return r;
   endfunction

   // rotate toward zero residual angle
   always_comb begin
      lane_in.u = rot_step(lane_i.u, step_idx);
      lane_in.v = rot_step(lane_i.v, step_idx);
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;

endmodule

// ===== rtl/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// UV sphere grid point to position, texture coordinates and cell indices.
// ----------------------------------------------------------------------------
// A grid point is taken on every cycle in which start is high; busy is never
// raised. Each point gives one result on rsp_strobe, passing in order through
// 1 input register, 25 division cells (one quotient bit each), 1 quadrant
// fold, 20 CORDIC cells, then rotate, multiply and round stages. The receiver
// cannot stall, so results must be taken when strobed. Segment counts must be
// written through the csr port while no point is in flight (not enforced).
`timescale 1ns / 1ps

module uv_sphere_vertex_generator
   import uvs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [SEG_W-1:0]        req_col,
   input  logic [SEG_W-1:0]        req_row,
   output logic                    rsp_strobe,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z,
   output logic [TEX_W-1:0]        rsp_tex_u,
   output logic [TEX_W-1:0]        rsp_tex_v,
   output logic [IDX_W-1:0]        rsp_tri_a0,
   output logic [IDX_W-1:0]        rsp_tri_a1,
   output logic [IDX_W-1:0]        rsp_tri_a2,
   output logic [IDX_W-1:0]        rsp_tri_b0,
   output logic [IDX_W-1:0]        rsp_tri_b1,
   output logic [IDX_W-1:0]        rsp_tri_b2,
   output logic                    rsp_cell_valid,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [SEG_W-1:0]        csr_wdata
);

   logic [SEG_W-1:0] cols_ff;
   logic [SEG_W-1:0] rows_ff;
   logic [SEG_W-1:0] cc;
   logic [SEG_W-1:0] rc;
   logic             accept;

   logic [LATENCY-1:0] vld_ff;
   side_type           side_ff [LATENCY];
   side_type           side_in;
   tex_type            tex_ff [TEX_DELAY];

   logic [SEG_W-1:0]   col_c;
   logic [SEG_W-1:0]   row_c;
   logic [SEG_W-1:0]   w;
   logic [2*SEG_W-1:0] row_w;
   logic [IDX_W-1:0]   top_idx;
   logic [IDX_W-1:0]   bot_idx;

   div_pair_type    div_bus [DIV_STEPS+1];
   div_pair_type    div_in;
   cordic_pair_type cor_bus [CORDIC_STEPS+1];
   cordic_pair_type cor_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign cc        = seg_count(cols_ff);
   assign rc        = seg_count(rows_ff);

   // segment count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= SEG_RESET;
         rows_ff <= SEG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMNS: cols_ff <= csr_wdata;
            CSR_ROWS:    rows_ff <= csr_wdata;
            default:     cols_ff <= cols_ff;
         endcase
      end
   end

   // strobe pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], accept};
      end
   end

   // clamp and triangle indices
   always_comb begin
      col_c   = (req_col > cc) ? cc : req_col;
      row_c   = (req_row > rc) ? rc : req_row;
      w       = SEG_W'(cc + SEG_W'(1));
      row_w   = row_c * w;
      top_idx = IDX_W'(row_w + (2*SEG_W)'(col_c));
      bot_idx = IDX_W'(top_idx + IDX_W'(w));
      side_in.cell_valid = (col_c < cc) && (row_c < rc);
      if (side_in.cell_valid) begin
         side_in.a0 = bot_idx;
         side_in.a1 = top_idx;
         side_in.a2 = IDX_W'(top_idx + IDX_W'(1));
         side_in.b0 = bot_idx;
         side_in.b1 = IDX_W'(top_idx + IDX_W'(1));
         side_in.b2 = IDX_W'(bot_idx + IDX_W'(1));
      end else begin
         side_in.a0 = '0;
         side_in.a1 = '0;
         side_in.a2 = '0;
         side_in.b0 = '0;
         side_in.b1 = '0;
         side_in.b2 = '0;
      end
      div_in.u.num = {col_c, 16'b0};
      div_in.u.rem = '0;
      div_in.v.num = {row_c, 16'b0};
      div_in.v.rem = '0;
   end

   // input register and sideband delay line
   always_ff @(posedge clock) begin
      div_bus[0] <= div_in;
      side_ff[0] <= side_in;
      for (int k = 1; k < LATENCY; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // division chain
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      uvs_div_cell u_div_cell (
         .clock  (clock),
         .div_u  (cc),
         .div_v  (rc),
         .lane_i (div_bus[k]),
         .lane_o (div_bus[k+1])
      );
   end

   // quadrant fold of both phases
   always_comb begin
      logic [31:0] p_u;
      logic [31:0] p_v;
      logic [31:0] s_u;
      logic [31:0] s_v;
      p_u = {div_bus[DIV_STEPS].u.num[15:0], 16'b0};
      p_v = {div_bus[DIV_STEPS].v.num[16:0], 15'b0};
      s_u = p_u + 32'h2000_0000;
      s_v = p_v + 32'h2000_0000;
      cor_in.u.quad = s_u[31:30];
      cor_in.v.quad = s_v[31:30];
      cor_in.u.z    = $signed(p_u - {s_u[31:30], 30'b0});
      cor_in.v.z    = $signed(p_v - {s_v[31:30], 30'b0});
      cor_in.u.x    = CORDIC_GAIN;
      cor_in.v.x    = CORDIC_GAIN;
      cor_in.u.y    = '0;
      cor_in.v.y    = '0;
   end

   // fold register and texture delay line
   always_ff @(posedge clock) begin
      cor_bus[0]  <= cor_in;
      tex_ff[0].u <= div_bus[DIV_STEPS].u.num[TEX_W-1:0];
      tex_ff[0].v <= div_bus[DIV_STEPS].v.num[TEX_W-1:0];
      for (int k = 1; k < TEX_DELAY; k++) begin
         tex_ff[k] <= tex_ff[k-1];
      end
   end

   // cordic chain
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      uvs_cordic_cell u_cordic_cell (
         .clock    (clock),
         .step_idx (STEP_IDX_W'(k)),
         .lane_i   (cor_bus[k]),
         .lane_o   (cor_bus[k+1])
      );
   end

   logic signed [CORDIC_W-1:0] ct_ff, st_ff, cp_ff, sp_ff;
   logic signed [CORDIC_W-1:0] ct_in, st_in, cp_in, sp_in;
   logic signed [63:0]         px_ff, pz_ff, py_ff;

   // turn by the quadrant
   always_comb begin
      cordic_lane_type lu;
      cordic_lane_type lv;
      lu = cor_bus[CORDIC_STEPS].u;
      lv = cor_bus[CORDIC_STEPS].v;
      unique case (lu.quad)
         2'd0:    begin ct_in = lu.x;  st_in = lu.y;  end
         2'd1:    begin ct_in = -lu.y; st_in = lu.x;  end
         2'd2:    begin ct_in = -lu.x; st_in = -lu.y; end
         default: begin ct_in = lu.y;  st_in = -lu.x; end
      endcase
      unique case (lv.quad)
         2'd0:    begin cp_in = lv.x;  sp_in = lv.y;  end
         2'd1:    begin cp_in = -lv.y; sp_in = lv.x;  end
         2'd2:    begin cp_in = -lv.x; sp_in = -lv.y; end
         default: begin cp_in = lv.y;  sp_in = -lv.x; end
      endcase
   end

   // rotate, multiply, round and saturate
   always_ff @(posedge clock) begin
      ct_ff <= ct_in;
      st_ff <= st_in;
      cp_ff <= cp_in;
      sp_ff <= sp_in;

      px_ff <= 64'(ct_ff) * 64'(sp_ff);
      pz_ff <= 64'(st_ff) * 64'(sp_ff);
      py_ff <= 64'(cp_ff);

      rsp_pos_x <= sat_pos((px_ff + (64'sd1 <<< 44)) >>> 45);
      rsp_pos_z <= sat_pos((pz_ff + (64'sd1 <<< 44)) >>> 45);
      rsp_pos_y <= sat_pos((py_ff + (64'sd1 <<< 14)) >>> 15);
   end

   assign rsp_strobe     = vld_ff[LATENCY-1];
   assign rsp_tex_u      = tex_ff[TEX_DELAY-1].u;
   assign rsp_tex_v      = tex_ff[TEX_DELAY-1].v;
   assign rsp_tri_a0     = side_ff[LATENCY-1].a0;
   assign rsp_tri_a1     = side_ff[LATENCY-1].a1;
   assign rsp_tri_a2     = side_ff[LATENCY-1].a2;
   assign rsp_tri_b0     = side_ff[LATENCY-1].b0;
   assign rsp_tri_b1     = side_ff[LATENCY-1].b1;
   assign rsp_tri_b2     = side_ff[LATENCY-1].b2;
   assign rsp_cell_valid = side_ff[LATENCY-1].cell_valid;

endmodule

// ===== sim/tb_uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator
// Self-checking testbench of the UV sphere vertex generator: a queue-fed
// driver sends grid points, a bit-exact predictor (CORDIC sine and cosine,
// division, cell indices) computes each vertex, and a monitor compares every
// strobed result in order. Segment counts are reprogrammed between phases,
// including zero, the maximum and values above it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;
   import uvs_pkg::*;

   typedef struct {
      logic [SEG_W-1:0] col;
      logic [SEG_W-1:0] row;
   } grid_point_type;

   typedef struct {
      logic signed [POS_W-1:0] px, py, pz;
      logic [TEX_W-1:0]        tu, tv;
      logic [IDX_W-1:0]        a0, a1, a2, b0, b1, b2;
      logic                    cv;
   } vertex_type;

   localparam longint ARCTAN_TURNS [20] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304
   };
   localparam int STALL_LIMIT = 2000;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [SEG_W-1:0] req_col = '0;
   logic [SEG_W-1:0] req_row = '0;
   logic rsp_strobe;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [TEX_W-1:0] rsp_tex_u, rsp_tex_v;
   logic [IDX_W-1:0] rsp_tri_a0, rsp_tri_a1, rsp_tri_a2;
   logic [IDX_W-1:0] rsp_tri_b0, rsp_tri_b1, rsp_tri_b2;
   logic rsp_cell_valid;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_COLUMNS;
   logic [SEG_W-1:0] csr_wdata = '0;

   grid_point_type pending_points[$];
   vertex_type     expected_vertices[$];
   logic [SEG_W-1:0] columns_reg = SEG_RESET;
   logic [SEG_W-1:0] rows_reg = SEG_RESET;
   int  send_idle_pct = 0;
   logic hold_send = 1'b0;
   int  stall_cycles = 0;
   bit  failed = 0;

   uv_sphere_vertex_generator dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // sine and cosine by rotation-mode cordic after quadrant folding
   function automatic void cordic_sin_cos(input logic [31:0] phase,
                                          output longint c, output longint s);
      logic [31:0] shifted;
      logic [1:0]  quad;
      longint z, x, y, dx, dy;
      shifted = phase + 32'h2000_0000;
      quad = shifted[31:30];
      z = $signed({32'd0, phase}) - longint'(quad) * 64'sd1073741824;
      if (z >= 64'sd2147483648) z -= 64'sd4294967296;
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 20; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ARCTAN_TURNS[i];
         end else begin
            x += dx;
            y -= dy;
            z += ARCTAN_TURNS[i];
         end
      end
      case (quad)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] clip_q15(input longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[POS_W-1:0];
   endfunction

   function automatic longint eff_count(input logic [SEG_W-1:0] r);
      if (r == 0) return 1;
      if (r > 256) return 256;
      return r;
   endfunction

   // expected vertex of one grid point under the given segment counts
   function automatic vertex_type predict_vertex(input logic [SEG_W-1:0] col_in,
                                                 input logic [SEG_W-1:0] row_in,
                                                 input logic [SEG_W-1:0] cols,
                                                 input logic [SEG_W-1:0] rows);
      vertex_type v;
      longint cc, rc, col, row, tu, tv, ct, st, cp, sp, w, top, bot;
      cc = eff_count(cols);
      rc = eff_count(rows);
      col = (col_in > cc) ? cc : col_in;
      row = (row_in > rc) ? rc : row_in;
      tu = (col << 16) / cc;
      tv = (row << 16) / rc;
      cordic_sin_cos(32'(tu << 16), ct, st);
      cordic_sin_cos(32'(tv << 15), cp, sp);
      v.px = clip_q15((ct * sp + (64'sd1 <<< 44)) >>> 45);
      v.py = clip_q15((cp + (64'sd1 <<< 14)) >>> 15);
      v.pz = clip_q15((st * sp + (64'sd1 <<< 44)) >>> 45);
      v.tu = tu[TEX_W-1:0];
      v.tv = tv[TEX_W-1:0];
      v.cv = (col < cc) && (row < rc);
      w = cc + 1;
      top = row * w + col;
      bot = (row + 1) * w + col;
      if (v.cv) begin
         v.a0 = bot[IDX_W-1:0];
         v.a1 = top[IDX_W-1:0];
         v.a2 = IDX_W'(top + 1);
         v.b0 = bot[IDX_W-1:0];
         v.b1 = IDX_W'(top + 1);
         v.b2 = IDX_W'(bot + 1);
      end else begin
         {v.a0, v.a1, v.a2, v.b0, v.b1, v.b2} = '0;
      end
      return v;
   endfunction

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
         failed = 1;
      end
   endfunction

   // driver: one grid point transaction per accepting edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_vertices.insert(expected_vertices.size(),
                                     predict_vertex(req_col, req_row,
                                                    columns_reg, rows_reg));
            void'(pending_points.pop_front());
         end
         if (!hold_send && pending_points.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            start   <= 1'b1;
            req_col <= pending_points[0].col;
            req_row <= pending_points[0].row;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: result transactions and register writes
   always @(posedge clock) begin
      vertex_type e;
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_COLUMNS) columns_reg <= csr_wdata;
         else rows_reg <= csr_wdata;
      end
      if (!reset && rsp_strobe) begin
         if (expected_vertices.size() == 0) begin
            $display("%0t unexpected result, expected none actual strobe", $time);
            failed = 1;
         end else begin
            e = expected_vertices.pop_front();
            check_field("pos_x", e.px, rsp_pos_x);
            check_field("pos_y", e.py, rsp_pos_y);
            check_field("pos_z", e.pz, rsp_pos_z);
            check_field("tex_u", e.tu, rsp_tex_u);
            check_field("tex_v", e.tv, rsp_tex_v);
            check_field("tri_a0", e.a0, rsp_tri_a0);
            check_field("tri_a1", e.a1, rsp_tri_a1);
            check_field("tri_a2", e.a2, rsp_tri_a2);
            check_field("tri_b0", e.b0, rsp_tri_b0);
            check_field("tri_b1", e.b1, rsp_tri_b1);
            check_field("tri_b2", e.b2, rsp_tri_b2);
            check_field("cell_valid", e.cv, rsp_cell_valid);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("uv_sphere_vertex_generator test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one register write, held until the accepting edge
   task automatic write_csr(input logic idx, input logic [SEG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic add_point(input int c, input int r);
      grid_point_type p;
      p.col = SEG_W'(c);
      p.row = SEG_W'(r);
      pending_points.insert(pending_points.size(), p);
   endtask

   // wait until every point is sent and every vertex has arrived
   task automatic drain_all();
      while (pending_points.size() > 0 || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      int cols_set [10] = '{1, 256, 0, 511, 3, 255, 300, 0, 0, 0};
      int rows_set [10] = '{1, 256, 0, 511, 200, 2, 17, 0, 0, 0};
      int cc, rc;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed points under reset counts: corners, poles, clamping, wide bits
      add_point(0, 0);      add_point(16, 16);   add_point(15, 15);
      add_point(8, 8);      add_point(4, 0);     add_point(0, 16);
      add_point(16, 0);     add_point(12, 3);    add_point(511, 511);
      add_point(511, 0);    add_point(0, 511);   add_point(256, 256);
      add_point(9'h155, 9'h0AA); add_point(9'h0AA, 9'h155);
      add_point(17, 5);     add_point(5, 17);    add_point(1, 15);
      add_point(15, 1);
      drain_all();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph >= 7) begin
            cols_set[ph] = $urandom_range(0, 511);
            rows_set[ph] = $urandom_range(0, 511);
         end
         write_csr(CSR_COLUMNS, SEG_W'(cols_set[ph]));
         write_csr(CSR_ROWS, SEG_W'(rows_set[ph]));
         send_idle_pct = (ph < 3) ? 23 : (ph < 6) ? 76 : 0;
         cc = int'(eff_count(SEG_W'(cols_set[ph])));
         rc = int'(eff_count(SEG_W'(rows_set[ph])));
         add_point(cc, rc);
         add_point(cc - 1, rc - 1);
         for (int k = 0; k < 151; k++) begin
            if ($urandom_range(0, 99) < 85)
               add_point($urandom_range(0, cc), $urandom_range(0, rc));
            else
               add_point($urandom_range(0, 511), $urandom_range(0, 511));
         end
         // hold the sender once until the pipeline is empty
         if (ph == 1) begin
            while (pending_points.size() > 60) @(posedge clock);
            hold_send <= 1'b1;
            @(posedge clock);
            while (expected_vertices.size() > 0) @(posedge clock);
            hold_send <= 1'b0;
         end
         drain_all();
      end

      if (!failed) begin
         $display("uv_sphere_vertex_generator test passed");
      end else begin
         $display("uv_sphere_vertex_generator test failed");
      end
      $finish;
   end

endmodule
